// ===== rtl/core/rgb_conv3x3_clamped_macros.svh =====
// Assertion macros for the 3x3 convolution block.
// Used by the port checker; needs clk and rst_n in scope.
`ifndef RGB_CONV3X3_CLAMPED_MACROS_SVH
`define RGB_CONV3X3_CLAMPED_MACROS_SVH

// Same-cycle implication, off while reset is held
`define RGBC3_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is held
`define RGBC3_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication, checked during reset too
`define RGBC3_ASSERT_NEXT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rgbc3_pkg.sv =====
// Shared types and constants of the 3x3 RGB convolution block.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package rgbc3_pkg;

  localparam int PIX_W     = 8;            // one color channel
  localparam int CH_N      = 3;            // red, green, blue
  localparam int PIXEL_W   = PIX_W * CH_N; // packed pixel, red lowest
  localparam int LINE_W    = 2 * PIXEL_W;  // one line store entry: both rows
  localparam int COEF_W    = 9;            // signed coefficient
  localparam int PROD_W    = PIX_W + 1 + COEF_W;
  localparam int PART_W    = PROD_W + 2;   // sum of three products
  localparam int CELL_N    = 3;            // window columns
  localparam int DIM_W     = 12;           // width/height register
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 3 * COEF_W;  // widest register: one kernel row

  localparam int MIN_DIM    = 3;
  localparam int WIDTH_RST  = 640;
  localparam int HEIGHT_RST = 480;
  localparam int OFFSET_LEVEL = 127;
  localparam int PIX_MAX    = 255;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MIDDLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOTTOM = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ADD_OFFSET    = 3'd5;

  typedef logic [PIXEL_W-1:0] pixel_t;
  typedef logic signed [COEF_W-1:0] coef_t;

  // One window column: pixel from two rows up, one row up, current row
  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } column_t;

  // Per-channel partial sums of one column, channel 0 (red) lowest
  typedef logic [CH_N-1:0][PART_W-1:0] part_vec_t;

  // Control from the top level to each cell
  typedef struct packed {
    logic shift;    // take the neighbor's column
    logic capture;  // register this column's partial sums
  } cell_ctl_t;

endpackage

// ===== rtl/core/rgb_conv3x3_clamped.sv =====
// Streaming 3x3 RGB convolution with clamped output, interior pixels only.
// Pipeline: input register with line store read, window cell shift, partial sum capture, output register.
// Throughput: one pixel per cycle while the output is not stalled, set by the simple dual-port line store
// (one read and one write per cycle) and the three-cell column chain.
// Reset (rst_n, synchronous): clears position, valid bits and registers to
// defaults; line store contents stay undefined and are never cleared.
`timescale 1ns / 1ps

module rgb_conv3x3_clamped #(
  parameter int MAX_WIDTH      = 2048,
  parameter int MAX_HEIGHT     = 2048,
  parameter int COEF_FRAC_BITS = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input pixel stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [rgbc3_pkg::PIXEL_W-1:0]     in_tdata,   // red_in, green_in, blue_in
  input  logic                              in_tuser,   // frame_start
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rgbc3_pkg::PIXEL_W-1:0]     out_tdata,  // red_out, green_out, blue_out
  output logic                              out_tlast,  // frame_last
  // configuration writes
  input  logic                              cfg_wr_en,
  input  logic [rgbc3_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rgbc3_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WCMP_W = (COL_W + 1 > rgbc3_pkg::DIM_W) ? COL_W + 1 : rgbc3_pkg::DIM_W;
  localparam int HCMP_W = (ROW_W + 1 > rgbc3_pkg::DIM_W) ? ROW_W + 1 : rgbc3_pkg::DIM_W;
  localparam int W_RST  = (rgbc3_pkg::WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH
                                                             : rgbc3_pkg::WIDTH_RST;
  localparam int H_RST  = (rgbc3_pkg::HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT
                                                               : rgbc3_pkg::HEIGHT_RST;
  localparam int KROW_W = rgbc3_pkg::CFG_DATA_W;
  localparam int CW     = rgbc3_pkg::COEF_W;

  // ---------------------------------------------------------------- config
  logic [WCMP_W-1:0] width_r,  width_nxt,  width_wr;
  logic [HCMP_W-1:0] height_r, height_nxt, height_wr;
  logic [KROW_W-1:0] ktop_r, kmid_r, kbot_r;
  logic              offset_en_r;

  // Saturate geometry as it is written
  always_comb begin
    width_wr  = WCMP_W'(cfg_data[rgbc3_pkg::DIM_W-1:0]);
    height_wr = HCMP_W'(cfg_data[rgbc3_pkg::DIM_W-1:0]);
    if (width_wr < WCMP_W'(rgbc3_pkg::MIN_DIM)) begin
      width_nxt = WCMP_W'(rgbc3_pkg::MIN_DIM);
    end else if (width_wr > WCMP_W'(MAX_WIDTH)) begin
      width_nxt = WCMP_W'(MAX_WIDTH);
    end else begin
      width_nxt = width_wr;
    end
    if (height_wr < HCMP_W'(rgbc3_pkg::MIN_DIM)) begin
      height_nxt = HCMP_W'(rgbc3_pkg::MIN_DIM);
    end else if (height_wr > HCMP_W'(MAX_HEIGHT)) begin
      height_nxt = HCMP_W'(MAX_HEIGHT);
    end else begin
      height_nxt = height_wr;
    end
  end

  // Decode register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= WCMP_W'(W_RST);
      height_r    <= HCMP_W'(H_RST);
      ktop_r      <= '0;
      kmid_r      <= '0;
      kbot_r      <= '0;
      offset_en_r <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        rgbc3_pkg::REG_IMAGE_WIDTH:   width_r     <= width_nxt;
        rgbc3_pkg::REG_IMAGE_HEIGHT:  height_r    <= height_nxt;
        rgbc3_pkg::REG_KERNEL_TOP:    ktop_r      <= cfg_data;
        rgbc3_pkg::REG_KERNEL_MIDDLE: kmid_r      <= cfg_data;
        rgbc3_pkg::REG_KERNEL_BOTTOM: kbot_r      <= cfg_data;
        rgbc3_pkg::REG_ADD_OFFSET:    offset_en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Unpack the nine coefficients, k0 at the low end of the top row
  rgbc3_pkg::coef_t coef [9];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      coef[i]     = ktop_r[i*CW +: CW];
      coef[3 + i] = kmid_r[i*CW +: CW];
      coef[6 + i] = kbot_r[i*CW +: CW];
    end
  end

  // ------------------------------------------------------- stage enables
  logic v1_r, v2_r, v3_r;
  logic en2, en3, en4;
  logic in_acc;

  assign en4       = !out_tvalid || out_tready;
  assign en3       = !v3_r || en4;
  assign en2       = !v2_r || en3;
  assign in_tready = !v1_r || en2;
  assign in_acc    = in_tvalid && in_tready;

  // ------------------------------------------------------------- position
  logic [COL_W-1:0] col_r, col_nxt, cur_c;
  logic [ROW_W-1:0] row_r, row_nxt, cur_r;
  logic [WCMP_W-1:0] c_ext;
  logic [HCMP_W-1:0] r_ext;
  logic              emit, last, row_end;

  always_comb begin
    cur_c   = in_tuser ? '0 : col_r;
    cur_r   = in_tuser ? '0 : row_r;
    c_ext   = WCMP_W'(cur_c);
    r_ext   = HCMP_W'(cur_r);
    emit    = (r_ext >= HCMP_W'(2)) && (c_ext >= WCMP_W'(2))
              && (r_ext < height_r) && (c_ext < width_r);
    last    = (r_ext == height_r - HCMP_W'(1)) && (c_ext == width_r - WCMP_W'(1));
    row_end = (c_ext + WCMP_W'(1)) >= width_r;
    if (row_end) begin
      col_nxt = '0;
      row_nxt = ((r_ext + HCMP_W'(1)) >= height_r) ? '0 : cur_r + ROW_W'(1);
    end else begin
      col_nxt = cur_c + COL_W'(1);
      row_nxt = cur_r;
    end
  end

  // Advance the raster position on every accepted pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------------------------------------- stage 1: line store read
  rgbc3_pkg::pixel_t               s1_pix_r;
  logic [COL_W-1:0]                s1_col_r;
  logic                            s1_emit_r, s1_last_r;
  logic                            byp_r;
  logic [rgbc3_pkg::LINE_W-1:0]    byp_line_r;
  logic [rgbc3_pkg::LINE_W-1:0]    rd_line, s1_line;
  rgbc3_pkg::pixel_t               s1_up, s1_mid;
  logic                            hit;
  logic                            s1_move;

  assign s1_line = byp_r ? byp_line_r : rd_line;
  assign s1_up   = s1_line[rgbc3_pkg::LINE_W-1:rgbc3_pkg::PIXEL_W];
  assign s1_mid  = s1_line[rgbc3_pkg::PIXEL_W-1:0];
  assign s1_move = v1_r && en2;
  // Same column written by the leaving beat: forward it
  assign hit     = v1_r && (cur_c == s1_col_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_tready) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r   <= in_tdata;
      s1_col_r   <= cur_c;
      s1_emit_r  <= emit;
      s1_last_r  <= last;
      byp_r      <= hit;
      byp_line_r <= {s1_mid, s1_pix_r};
    end
  end

  rgbc3_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (cur_c),
    .rd_data (rd_line),
    .wr_en   (s1_move),
    .wr_addr (s1_col_r),
    .wr_data ({s1_mid, s1_pix_r})
  );

  // ------------------------------------------------ stage 2: window cells
  logic s2_emit_r, s2_last_r;
  logic s3_emit_r, s3_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_emit_r <= s1_emit_r;
      s2_last_r <= s1_last_r;
    end
    if (en3 && v2_r) begin
      s3_emit_r <= s2_emit_r;
      s3_last_r <= s2_last_r;
    end
  end

  rgbc3_pkg::cell_ctl_t  cell_ctl;
  rgbc3_pkg::column_t    col_chain [rgbc3_pkg::CELL_N + 1];
  rgbc3_pkg::part_vec_t  part      [rgbc3_pkg::CELL_N];

  assign cell_ctl.shift   = s1_move;
  assign cell_ctl.capture = en3 && v2_r;

  // Newest column enters at the right end of the chain
  assign col_chain[rgbc3_pkg::CELL_N] = '{top: s1_up, mid: s1_mid, bot: s1_pix_r};

  // Column b of the window meets the kernel rotated by 180 degrees
  for (genvar b = 0; b < rgbc3_pkg::CELL_N; b++) begin : g_cell
    rgbc3_cell u_cell (
      .clk      (clk),
      .ctl      (cell_ctl),
      .col_in   (col_chain[b + 1]),
      .coef_top (coef[8 - b]),
      .coef_mid (coef[5 - b]),
      .coef_bot (coef[2 - b]),
      .col_out  (col_chain[b]),
      .part_out (part[b])
    );
  end

  // --------------------------------------------- stage 4: sum and output
  rgbc3_sum_clamp #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_sum_clamp (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (en4),
    .res_valid  (v3_r && s3_emit_r),
    .res_last   (s3_last_r),
    .add_offset (offset_en_r),
    .part0      (part[0]),
    .part1      (part[1]),
    .part2      (part[2]),
    .out_valid  (out_tvalid),
    .out_data   (out_tdata),
    .out_last   (out_tlast)
  );

endmodule

// ===== rtl/core/rgbc3_line_store.sv =====
// Line store for two previous image rows, one entry per column.
// Depends on rgbc3_pkg for the entry width.
`timescale 1ns / 1ps

module rgbc3_line_store #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                               clk,
  input  logic                               rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]       rd_addr,
  output logic [rgbc3_pkg::LINE_W-1:0]       rd_data,
  input  logic                               wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]       wr_addr,
  input  logic [rgbc3_pkg::LINE_W-1:0]       wr_data
);

  logic [rgbc3_pkg::LINE_W-1:0] mem_r [MAX_WIDTH];
  logic [rgbc3_pkg::LINE_W-1:0] rd_data_r;

  // Write one entry, read one entry; read data registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/rgbc3_cell.sv =====
// One window column cell: holds three pixels, hands them to its left
// neighbor on shift, and registers the column's weighted sums. Uses rgbc3_pkg.
`timescale 1ns / 1ps

module rgbc3_cell (
  input  logic                  clk,
  input  rgbc3_pkg::cell_ctl_t  ctl,
  input  rgbc3_pkg::column_t    col_in,
  input  rgbc3_pkg::coef_t      coef_top,
  input  rgbc3_pkg::coef_t      coef_mid,
  input  rgbc3_pkg::coef_t      coef_bot,
  output rgbc3_pkg::column_t    col_out,
  output rgbc3_pkg::part_vec_t  part_out
);

  rgbc3_pkg::column_t   col_r;
  rgbc3_pkg::part_vec_t part_r;
  rgbc3_pkg::part_vec_t part_nxt;

  logic signed [rgbc3_pkg::PROD_W-1:0] prod_top [rgbc3_pkg::CH_N];
  logic signed [rgbc3_pkg::PROD_W-1:0] prod_mid [rgbc3_pkg::CH_N];
  logic signed [rgbc3_pkg::PROD_W-1:0] prod_bot [rgbc3_pkg::CH_N];

  // Weight each channel of the three pixels and add them up
  always_comb begin
    for (int j = 0; j < rgbc3_pkg::CH_N; j++) begin
      prod_top[j] = $signed({1'b0, col_r.top[j*rgbc3_pkg::PIX_W +: rgbc3_pkg::PIX_W]})
                    * coef_top;
      prod_mid[j] = $signed({1'b0, col_r.mid[j*rgbc3_pkg::PIX_W +: rgbc3_pkg::PIX_W]})
                    * coef_mid;
      prod_bot[j] = $signed({1'b0, col_r.bot[j*rgbc3_pkg::PIX_W +: rgbc3_pkg::PIX_W]})
                    * coef_bot;
      part_nxt[j] = rgbc3_pkg::PART_W'(prod_top[j]) + rgbc3_pkg::PART_W'(prod_mid[j])
                    + rgbc3_pkg::PART_W'(prod_bot[j]);
    end
  end

  // Advance the column and hold the partial sums for the adder stage
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      col_r <= col_in;
    end
    if (ctl.capture) begin
      part_r <= part_nxt;
    end
  end

  assign col_out  = col_r;
  assign part_out = part_r;

endmodule

// ===== rtl/core/rgbc3_sum_clamp.sv =====
// Adds the three column partial sums and the optional offset, then
// clamps to 0..255 and drops the fraction. Holds the output beat. Uses rgbc3_pkg.
`timescale 1ns / 1ps

module rgbc3_sum_clamp #(
  parameter int COEF_FRAC_BITS = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  logic                          res_valid,
  input  logic                          res_last,
  input  logic                          add_offset,
  input  rgbc3_pkg::part_vec_t          part0,
  input  rgbc3_pkg::part_vec_t          part1,
  input  rgbc3_pkg::part_vec_t          part2,
  output logic                          out_valid,
  output logic [rgbc3_pkg::PIXEL_W-1:0] out_data,
  output logic                          out_last
);

  localparam int SUM_BASE = (rgbc3_pkg::PART_W + 2 > COEF_FRAC_BITS + 8) ?
                            rgbc3_pkg::PART_W + 2 : COEF_FRAC_BITS + 8;
  localparam int SUM_W    = SUM_BASE + 1;
  localparam int OFFSET_VAL = rgbc3_pkg::OFFSET_LEVEL * (2 ** COEF_FRAC_BITS);
  localparam logic signed [SUM_W-1:0] OFFSET  = SUM_W'(OFFSET_VAL);
  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(rgbc3_pkg::PIX_MAX);

  logic signed [SUM_W-1:0]        sum_c   [rgbc3_pkg::CH_N];
  logic signed [SUM_W-1:0]        shift_c [rgbc3_pkg::CH_N];
  logic [rgbc3_pkg::PIXEL_W-1:0]  data_nxt;
  logic                           valid_r;
  logic                           last_r;
  logic [rgbc3_pkg::PIXEL_W-1:0]  data_r;

  // Sum, offset and clamp each channel
  always_comb begin
    for (int j = 0; j < rgbc3_pkg::CH_N; j++) begin
      sum_c[j] = SUM_W'($signed(part0[j])) + SUM_W'($signed(part1[j]))
                 + SUM_W'($signed(part2[j])) + (add_offset ? OFFSET : '0);
      shift_c[j] = sum_c[j] >>> COEF_FRAC_BITS;
      if (sum_c[j][SUM_W-1]) begin
        data_nxt[j*rgbc3_pkg::PIX_W +: rgbc3_pkg::PIX_W] = '0;
      end else if (shift_c[j] > SAT_MAX) begin
        data_nxt[j*rgbc3_pkg::PIX_W +: rgbc3_pkg::PIX_W] = '1;
      end else begin
        data_nxt[j*rgbc3_pkg::PIX_W +: rgbc3_pkg::PIX_W] =
          shift_c[j][rgbc3_pkg::PIX_W-1:0];
      end
    end
  end

  // Output register: load when empty or the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      data_r <= data_nxt;
      last_r <= res_last;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;
  assign out_last  = last_r;

endmodule

// ===== rtl/core/rgbc3_port_checker.sv =====
// Port-level checks for the 3x3 convolution block, bound to the top level.
// Depends on rgbc3_pkg and rgb_conv3x3_clamped_macros.svh.
`timescale 1ns / 1ps
`include "rgb_conv3x3_clamped_macros.svh"

module rgbc3_port_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [rgbc3_pkg::PIXEL_W-1:0] out_tdata,
  input logic                          out_tlast
);

  // Reset empties the output register
  `RGBC3_ASSERT_NEXT_RST(a_reset_empty, !rst_n, !out_tvalid, "result beat right after reset")

  // A stalled result beat holds its payload
  `RGBC3_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result beat changed")

  // With the output draining, the pipeline must take a pixel
  `RGBC3_ASSERT_NOW(a_in_ready, !out_tvalid || out_tready, in_tready, "input stalled while output drains")

endmodule

bind rgb_conv3x3_clamped rgbc3_port_checker u_port_checker (.*);
